@@ hdl/rcst_pkg.sv @@
package rcst_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned ADDR_W        = 8;
  localparam int unsigned PTR_W         = 9;
  localparam int unsigned CNT_W         = 16;
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned TOTAL_W       = 32;
  localparam int unsigned IN_W          = 48;
  localparam int unsigned OUT_W         = 112;

  typedef enum logic [1:0] {
    REQ_TRACK   = 2'd0,
    REQ_RETAIN  = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_STATS   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_DISABLED = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_BAD_IDX  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_MODIFY,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [5:0]        pad;
    logic [ADDR_W-1:0] entry_index;
    logic [KEY_W-1:0]  string_offset;
    logic [1:0]        req_type;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         pad;
    logic [PTR_W-1:0]   entries_used;
    logic [PTR_W-1:0]   live_entries;
    logic [TOTAL_W-1:0] free_total;
    logic [TOTAL_W-1:0] alloc_total;
    logic [CNT_W-1:0]   result_count;
    logic [ADDR_W-1:0]  result_index;
    logic [1:0]         status;
  } out_item_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == '1) ? c : c + CNT_W'(1);
  endfunction

endpackage

@@ hdl/refcount_string_table_core.sv @@
// Reference-count table keyed by a 32-bit string offset.
// Slave stream: one request per transaction, tdata = {entry_index, string_offset,
// req_type} (req_type in the lowest bits). Master stream: one result per request.
// cfg_we_i/cfg_wdata_i write the enable bit; write only while the block is idle.
// Track walks the used slots through a simple dual-port entry RAM and one key
// comparator, one slot per cycle, until a live key match or the end of the used
// slots. Retain and release go through a RAM read, an update and the response;
// statistics and rejected requests go straight to the response. The live count and
// the totals are kept in counters, so statistics never scan the RAM.
// Only one request is in flight: tready is high in the idle state only.
// A finished result sits in the output register; the next request may be
// taken meanwhile, but its result waits until the receiver takes the first.
// Reset: empty table, totals zero, table enabled, no result pending. The RAM
// is not cleared; stale slots at or above the used count are never used.
module refcount_string_table_core
  import rcst_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // req_type[1:0], string_offset[33:2], entry_index[41:34], zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // status[1:0], result_index[9:2], result_count[25:10], alloc_total[57:26],
  // free_total[89:58], live_entries[98:90], entries_used[107:99], zero pad
  output logic [OUT_W-1:0] m_axis_tdata
);

  state_e state_q, state_d;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_data;

  logic              en_q;
  in_item_t          in_item;
  req_e              req_q, req_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [ADDR_W-1:0] idx_q, idx_d;

  logic [PTR_W-1:0]   used_q, used_d;
  logic [PTR_W-1:0]   live_q, live_d;
  logic [TOTAL_W-1:0] alloc_q, alloc_d;
  logic [TOTAL_W-1:0] free_q, free_d;

  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [ADDR_W-1:0] cmp_ptr_q, cmp_ptr_d;

  status_e           res_status_q, res_status_d;
  logic [ADDR_W-1:0] res_index_q, res_index_d;
  logic [CNT_W-1:0]  res_count_q, res_count_d;

  logic      out_vld_q;
  out_item_t out_q;
  logic      out_free;
  logic      in_acc;
  logic      scan_hit;
  logic      scan_miss;
  logic      idx_bad;
  logic [CNT_W-1:0] upd_count;

  assign in_item       = in_item_t'(s_axis_tdata);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_vld_q || m_axis_tready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  assign scan_hit  = (state_q == ST_SCAN) && cmp_vld_q && (rd_data_q.count != '0)
                     && (rd_data_q.key == key_q);
  assign scan_miss = (state_q == ST_SCAN) && !cmp_vld_q && (rd_ptr_q == used_q);
  assign idx_bad   = ({1'b0, in_item.entry_index} >= used_q);
  assign upd_count = (req_q == REQ_RELEASE) ? rd_data_q.count - CNT_W'(1)
                                            : sat_inc(rd_data_q.count);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_item.req_type != REQ_STATS && !en_q) begin
            state_d = ST_RESP;
          end else if (in_item.req_type == REQ_STATS) begin
            state_d = ST_RESP;
          end else if (in_item.req_type == REQ_TRACK) begin
            state_d = (used_q == PTR_W'(TABLE_ENTRIES)) ? ST_RESP : ST_SCAN;
          end else begin
            state_d = idx_bad ? ST_RESP : ST_READ;
          end
        end
      end
      ST_SCAN:   if (scan_hit || scan_miss) state_d = ST_RESP;
      ST_READ:   state_d = ST_MODIFY;
      ST_MODIFY: state_d = ST_RESP;
      ST_RESP:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    req_d        = req_q;
    key_d        = key_q;
    idx_d        = idx_q;
    used_d       = used_q;
    live_d       = live_q;
    alloc_d      = alloc_q;
    free_d       = free_q;
    rd_ptr_d     = rd_ptr_q;
    cmp_vld_d    = 1'b0;
    cmp_ptr_d    = cmp_ptr_q;
    res_status_d = res_status_q;
    res_index_d  = res_index_q;
    res_count_d  = res_count_q;
    rd_addr      = idx_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = rd_data_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_d        = req_e'(in_item.req_type);
          key_d        = in_item.string_offset;
          idx_d        = in_item.entry_index;
          rd_ptr_d     = '0;
          res_status_d = STAT_DONE;
          res_index_d  = '0;
          res_count_d  = '0;
          priority if (in_item.req_type != REQ_STATS && !en_q) begin
            res_status_d = STAT_DISABLED;
          end else if (in_item.req_type == REQ_STATS) begin
            res_status_d = STAT_DONE;
          end else if (in_item.req_type == REQ_TRACK) begin
            if (used_q == PTR_W'(TABLE_ENTRIES)) res_status_d = STAT_FULL;
          end else begin
            if (idx_bad) res_status_d = STAT_BAD_IDX;
          end
        end
      end
      ST_SCAN: begin
        rd_addr = rd_ptr_q[ADDR_W-1:0];
        if (!scan_hit && rd_ptr_q < used_q) begin
          rd_ptr_d  = rd_ptr_q + PTR_W'(1);
          cmp_vld_d = 1'b1;
          cmp_ptr_d = rd_ptr_q[ADDR_W-1:0];
        end
        if (scan_hit) begin
          wr_en         = 1'b1;
          wr_addr       = cmp_ptr_q;
          wr_data.key   = key_q;
          wr_data.count = sat_inc(rd_data_q.count);
          alloc_d       = alloc_q + TOTAL_W'(1);
          res_index_d   = cmp_ptr_q;
          res_count_d   = sat_inc(rd_data_q.count);
        end else if (scan_miss) begin
          wr_en         = 1'b1;
          wr_addr       = used_q[ADDR_W-1:0];
          wr_data.key   = key_q;
          wr_data.count = CNT_W'(1);
          used_d        = used_q + PTR_W'(1);
          live_d        = live_q + PTR_W'(1);
          alloc_d       = alloc_q + TOTAL_W'(1);
          res_index_d   = used_q[ADDR_W-1:0];
          res_count_d   = CNT_W'(1);
        end
      end
      ST_READ: rd_addr = idx_q;
      ST_MODIFY: begin
        if (rd_data_q.count == '0) begin
          res_status_d = STAT_BAD_IDX;
        end else begin
          wr_en         = 1'b1;
          wr_data.count = upd_count;
          res_count_d   = upd_count;
          if (req_q == REQ_RELEASE && upd_count == '0) begin
            live_d = live_q - PTR_W'(1);
            free_d = free_q + TOTAL_W'(1);
          end
        end
      end
      ST_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      en_q      <= 1'b1;
      used_q    <= '0;
      live_q    <= '0;
      alloc_q   <= '0;
      free_q    <= '0;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      live_q    <= live_d;
      alloc_q   <= alloc_d;
      free_q    <= free_d;
      cmp_vld_q <= cmp_vld_d;
      if (cfg_we_i) en_q <= cfg_wdata_i;
      if (state_q == ST_RESP && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    rd_ptr_q     <= rd_ptr_d;
    cmp_ptr_q    <= cmp_ptr_d;
    res_status_q <= res_status_d;
    res_index_q  <= res_index_d;
    res_count_q  <= res_count_d;
    if (state_q == ST_RESP && out_free) begin
      out_q.pad          <= '0;
      out_q.status       <= res_status_q;
      out_q.result_index <= res_index_q;
      out_q.result_count <= res_count_q;
      out_q.alloc_total  <= alloc_q;
      out_q.free_total   <= free_q;
      out_q.live_entries <= live_q;
      out_q.entries_used <= used_q;
    end
  end

`ifndef SYNTHESIS
  a_live_le_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= used_q) else $error("live count above used slots");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= PTR_W'(TABLE_ENTRIES)) else $error("used slots above table depth");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> (used_q == $past(used_q) + PTR_W'(1)))
    else $error("used slots moved by more than one");

  a_alloc_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (alloc_q != $past(alloc_q)) |-> (state_q == ST_RESP && $past(state_q) == ST_SCAN))
    else $error("allocation total changed outside a track");

  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && cmp_vld_q) |-> ({1'b0, cmp_ptr_q} < used_q))
    else $error("scan compare beyond used slots");
`endif

endmodule
